/* hw/rtl/csru_pkg.sv */
// Shared types and constants for the smoothstep resistivity update unit.
// No dependencies; every other file imports it.
`default_nettype none
package csru_pkg;

  localparam int WORD_BITS = 32;
  localparam int FRAC_BITS = 16;
  localparam int REG_W     = 31;
  localparam int SUM_W     = 64;
  localparam int ROOT_W    = 32;
  localparam int Q_W       = FRAC_BITS + 1;

  localparam logic [Q_W-1:0] ONE_Q = Q_W'(1) << FRAC_BITS;
  localparam logic [REG_W-1:0] WMAX_U = {REG_W{1'b1}};

  localparam logic [1:0] REG_RESIST_MAX = 2'd0;
  localparam logic [1:0] REG_RAMP_START = 2'd1;
  localparam logic [1:0] REG_RAMP_FULL  = 2'd2;

  typedef struct packed {
    logic signed [WORD_BITS-1:0] current_form;
    logic signed [WORD_BITS-1:0] edge_dx;
    logic signed [WORD_BITS-1:0] edge_dy;
    logic signed [WORD_BITS-1:0] edge_dz;
    logic signed [WORD_BITS-1:0] emf_in;
  } item_t;

  typedef struct packed {
    logic signed [WORD_BITS-1:0] emf_out;
    logic                        saturated;
  } result_t;

  function automatic logic [WORD_BITS-1:0] mag_w(input logic [WORD_BITS-1:0] v);
    return v[WORD_BITS-1] ? (~v + WORD_BITS'(1)) : v;
  endfunction

endpackage
`default_nettype wire

/* hw/rtl/current_smoothstep_resistivity_update_unit.sv */
// Smoothstep artificial resistivity update, one mesh edge per transfer.
// Uses csru_pkg, csru_sqrt_cell and csru_div_cell.
//
// The unit takes one edge per clock while item_ready is high and returns one
// result per edge, in order, through three entry/product stages, 32 square-root
// cells (edge length), 48 division cells (current density), a select stage,
// 16 division cells (ramp position q), four multiply stages and the output
// register. Sustained throughput is one edge per cycle; the whole chain
// advances together and holds only while a result waits at the output, so
// item_ready follows result_ready. The user must write registers through wr_en,
// wr_index and wr_data only while no edge is in flight; the block does not
// enforce it. A zero resist_max passes emf_in straight through with saturated low.
`default_nettype none
module current_smoothstep_resistivity_update_unit import csru_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             item_valid,
  output logic                  item_ready,
  input  wire item_t            item,
  output logic                  result_valid,
  input  wire logic             result_ready,
  output result_t               result,
  input  wire logic             wr_en,
  input  wire logic [1:0]       wr_index,
  input  wire logic [REG_W-1:0] wr_data
);

  localparam int W      = WORD_BITS;
  localparam int F      = FRAC_BITS;
  localparam int DNUM_W = W + F;
  localparam int RES_W  = W + F + 1;

  typedef struct packed {
    logic         jneg;
    logic [W-1:0] jm;
    logic [W-1:0] e;
  } side_a_t;

  typedef struct packed {
    logic           jneg;
    logic [W-1:0]   jm;
    logic [W-1:0]   e;
    logic           sat;
    logic           hard;
    logic           hard_on;
    logic           use_div;
    logic [Q_W-1:0] qfix;
  } side_b_t;

  localparam int SA_W = $bits(side_a_t);
  localparam int SB_W = $bits(side_b_t);

  logic en;
  assign en         = !result_valid || result_ready;
  assign item_ready = en;

  // Configuration registers.
  logic [REG_W-1:0] resist_max, ramp_start, ramp_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      resist_max <= '0;
      ramp_start <= '0;
      ramp_full  <= '0;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_RESIST_MAX: resist_max <= wr_data;
        REG_RAMP_START: ramp_start <= wr_data;
        REG_RAMP_FULL:  ramp_full  <= wr_data;
        default: ;
      endcase
    end
  end

  // Entry register.
  logic  v0;
  item_t it0;
  always_ff @(posedge clk) begin
    if (rst) v0 <= 1'b0;
    else if (en) v0 <= item_valid;
  end
  always_ff @(posedge clk) begin
    if (en) it0 <= item;
  end

  // Square the component magnitudes.
  logic            v1;
  logic [2*W-1:0]  sqx, sqy, sqz;
  side_a_t         sa1;
  logic [W-1:0]    ax, ay, az;

  always_comb begin
    ax = mag_w(it0.edge_dx);
    ay = mag_w(it0.edge_dy);
    az = mag_w(it0.edge_dz);
  end

  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else if (en) v1 <= v0;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      sqx      <= ax * ax;
      sqy      <= ay * ay;
      sqz      <= az * az;
      sa1.jneg <= it0.current_form[W-1];
      sa1.jm   <= mag_w(it0.current_form);
      sa1.e    <= it0.emf_in;
    end
  end

  // Sum of squares; three terms of at most 2^62 cannot overflow 64 bits.
  logic        v2;
  logic [SUM_W-1:0] sum2;
  side_a_t     sa2;
  always_ff @(posedge clk) begin
    if (rst) v2 <= 1'b0;
    else if (en) v2 <= v1;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      sum2 <= sqx + sqy + sqz;
      sa2  <= sa1;
    end
  end

  // Square-root chain.
  logic              sq_v    [0:ROOT_W];
  logic [SUM_W-1:0]  sq_n    [0:ROOT_W];
  logic [ROOT_W-1:0] sq_root [0:ROOT_W];
  logic [ROOT_W+1:0] sq_rem  [0:ROOT_W];
  logic [SA_W-1:0]   sq_side [0:ROOT_W];

  assign sq_v[0]    = v2;
  assign sq_n[0]    = sum2;
  assign sq_root[0] = '0;
  assign sq_rem[0]  = '0;
  assign sq_side[0] = sa2;

  for (genvar i = 0; i < ROOT_W; i++) begin : g_sqrt
    csru_sqrt_cell #(.SIDE_W(SA_W)) u_cell (
      .clk      (clk),
      .rst      (rst),
      .en       (en),
      .vin      (sq_v[i]),
      .n_in     (sq_n[i]),
      .root_in  (sq_root[i]),
      .rem_in   (sq_rem[i]),
      .side_in  (sq_side[i]),
      .vout     (sq_v[i+1]),
      .n_out    (sq_n[i+1]),
      .root_out (sq_root[i+1]),
      .rem_out  (sq_rem[i+1]),
      .side_out (sq_side[i+1])
    );
  end

  // Density division: (|J| << F) / max(len, 1).
  side_a_t sa3;
  assign sa3 = side_a_t'(sq_side[ROOT_W]);

  logic              dv_v    [0:DNUM_W];
  logic [ROOT_W-1:0] dv_rem  [0:DNUM_W];
  logic [DNUM_W-1:0] dv_num  [0:DNUM_W];
  logic [DNUM_W-1:0] dv_quo  [0:DNUM_W];
  logic [ROOT_W-1:0] dv_den  [0:DNUM_W];
  logic [SA_W-1:0]   dv_side [0:DNUM_W];

  assign dv_v[0]    = sq_v[ROOT_W];
  assign dv_rem[0]  = '0;
  assign dv_num[0]  = {sa3.jm, {F{1'b0}}};
  assign dv_quo[0]  = '0;
  assign dv_den[0]  = (sq_root[ROOT_W] == '0) ? ROOT_W'(1) : sq_root[ROOT_W];
  assign dv_side[0] = sq_side[ROOT_W];

  for (genvar i = 0; i < DNUM_W; i++) begin : g_dens
    csru_div_cell #(.NUM_W(DNUM_W), .DEN_W(ROOT_W), .SIDE_W(SA_W)) u_cell (
      .clk      (clk),
      .rst      (rst),
      .en       (en),
      .vin      (dv_v[i]),
      .rem_in   (dv_rem[i]),
      .num_in   (dv_num[i]),
      .quo_in   (dv_quo[i]),
      .den_in   (dv_den[i]),
      .side_in  (dv_side[i]),
      .vout     (dv_v[i+1]),
      .rem_out  (dv_rem[i+1]),
      .num_out  (dv_num[i+1]),
      .quo_out  (dv_quo[i+1]),
      .den_out  (dv_den[i+1]),
      .side_out (dv_side[i+1])
    );
  end

  // Clip the density and pick the ramp case.
  side_a_t          sa4;
  logic             dens_big;
  logic [REG_W-1:0] dens;
  side_b_t          sb_next;

  always_comb begin
    sa4      = side_a_t'(dv_side[DNUM_W]);
    dens_big = |dv_quo[DNUM_W][DNUM_W-1:REG_W];
    dens     = dens_big ? WMAX_U : dv_quo[DNUM_W][REG_W-1:0];
    sb_next.jneg    = sa4.jneg;
    sb_next.jm      = sa4.jm;
    sb_next.e       = sa4.e;
    sb_next.sat     = dens_big;
    sb_next.hard    = ramp_full <= ramp_start;
    sb_next.hard_on = dens > ramp_start;
    sb_next.use_div = (ramp_full > ramp_start) && (dens > ramp_start) && (dens < ramp_full);
    sb_next.qfix    = (dens >= ramp_full) ? ONE_Q : '0;
  end

  logic             v4;
  side_b_t          sb4;
  logic [REG_W-1:0] qrem4, qden4;
  always_ff @(posedge clk) begin
    if (rst) v4 <= 1'b0;
    else if (en) v4 <= dv_v[DNUM_W];
  end
  always_ff @(posedge clk) begin
    if (en) begin
      sb4   <= sb_next;
      qrem4 <= dens - ramp_start;
      qden4 <= ramp_full - ramp_start;
    end
  end

  // Ramp position division: only its quotient matters when use_div is set.
  logic             qv_v    [0:F];
  logic [REG_W-1:0] qv_rem  [0:F];
  logic [F-1:0]     qv_num  [0:F];
  logic [F-1:0]     qv_quo  [0:F];
  logic [REG_W-1:0] qv_den  [0:F];
  logic [SB_W-1:0]  qv_side [0:F];

  assign qv_v[0]    = v4;
  assign qv_rem[0]  = qrem4;
  assign qv_num[0]  = '0;
  assign qv_quo[0]  = '0;
  assign qv_den[0]  = qden4;
  assign qv_side[0] = sb4;

  for (genvar i = 0; i < F; i++) begin : g_ramp
    csru_div_cell #(.NUM_W(F), .DEN_W(REG_W), .SIDE_W(SB_W)) u_cell (
      .clk      (clk),
      .rst      (rst),
      .en       (en),
      .vin      (qv_v[i]),
      .rem_in   (qv_rem[i]),
      .num_in   (qv_num[i]),
      .quo_in   (qv_quo[i]),
      .den_in   (qv_den[i]),
      .side_in  (qv_side[i]),
      .vout     (qv_v[i+1]),
      .rem_out  (qv_rem[i+1]),
      .num_out  (qv_num[i+1]),
      .quo_out  (qv_quo[i+1]),
      .den_out  (qv_den[i+1]),
      .side_out (qv_side[i+1])
    );
  end

  // q^2 and (3 - 2q).
  side_b_t          sb5_in;
  logic [Q_W-1:0]   q;
  logic [2*Q_W-1:0] qq;
  assign sb5_in = side_b_t'(qv_side[F]);
  assign q      = sb5_in.use_div ? {1'b0, qv_quo[F]} : sb5_in.qfix;
  assign qq     = q * q;

  logic           v5;
  side_b_t        sb5;
  logic [Q_W-1:0] q2_5;
  logic [Q_W:0]   w5;
  always_ff @(posedge clk) begin
    if (rst) v5 <= 1'b0;
    else if (en) v5 <= qv_v[F];
  end
  always_ff @(posedge clk) begin
    if (en) begin
      sb5  <= sb5_in;
      q2_5 <= qq[F +: Q_W];
      w5   <= (Q_W+1)'(3) * {1'b0, ONE_Q} - {q, 1'b0};
    end
  end

  // Smoothstep S = q2 * (3 - 2q) >> F.
  logic [2*Q_W:0] sw;
  assign sw = q2_5 * w5;

  logic           v6;
  side_b_t        sb6;
  logic [Q_W-1:0] s6;
  always_ff @(posedge clk) begin
    if (rst) v6 <= 1'b0;
    else if (en) v6 <= v5;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      sb6 <= sb5;
      s6  <= sw[F +: Q_W];
    end
  end

  // eta = resist_max * S >> F, or the hard step.
  logic [REG_W+Q_W-1:0] rs;
  assign rs = resist_max * s6;

  logic             v7;
  side_b_t          sb7;
  logic [REG_W-1:0] eta7;
  always_ff @(posedge clk) begin
    if (rst) v7 <= 1'b0;
    else if (en) v7 <= v6;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      sb7  <= sb6;
      eta7 <= sb6.hard ? (sb6.hard_on ? resist_max : '0) : rs[F +: REG_W];
    end
  end

  // Resistive term magnitude eta * |J| >> F.
  logic [REG_W+W-1:0] ej;
  assign ej = eta7 * sb7.jm;

  logic             v8;
  side_b_t          sb8;
  logic [RES_W-2:0] pm8;
  always_ff @(posedge clk) begin
    if (rst) v8 <= 1'b0;
    else if (en) v8 <= v7;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      sb8 <= sb7;
      pm8 <= ej[REG_W+W-1:F];
    end
  end

  // Add to the EMF, clip to the word range, drop the update when disabled.
  logic signed [RES_W-1:0] e_x, pm_x, res;
  logic                    hi, lo;
  result_t                 res_next;

  always_comb begin
    e_x  = RES_W'(signed'(sb8.e));
    pm_x = signed'({1'b0, pm8});
    res  = sb8.jneg ? (e_x - pm_x) : (e_x + pm_x);
    hi   = res > RES_W'(signed'({1'b0, WMAX_U}));
    lo   = res < RES_W'(signed'({1'b1, {REG_W{1'b0}}}));
    if (resist_max == '0) begin
      res_next.emf_out   = signed'(sb8.e);
      res_next.saturated = 1'b0;
    end else begin
      res_next.emf_out   = hi ? signed'({1'b0, WMAX_U}) :
                           lo ? signed'({1'b1, {REG_W{1'b0}}}) : res[W-1:0];
      res_next.saturated = sb8.sat || hi || lo;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) result_valid <= 1'b0;
    else if (en) result_valid <= v8;
  end
  always_ff @(posedge clk) begin
    if (en) result <= res_next;
  end

endmodule
`default_nettype wire

/* hw/rtl/csru_sqrt_cell.sv */
// One digit cell of the pipelined integer square root: one root bit per cell.
// Depends on csru_pkg for the radicand and root widths.
`default_nettype none
module csru_sqrt_cell import csru_pkg::*; #(
  parameter int SIDE_W = 1
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              en,
  input  wire logic              vin,
  input  wire logic [SUM_W-1:0]  n_in,
  input  wire logic [ROOT_W-1:0] root_in,
  input  wire logic [ROOT_W+1:0] rem_in,
  input  wire logic [SIDE_W-1:0] side_in,
  output logic                   vout,
  output logic [SUM_W-1:0]       n_out,
  output logic [ROOT_W-1:0]      root_out,
  output logic [ROOT_W+1:0]      rem_out,
  output logic [SIDE_W-1:0]      side_out
);

  logic [ROOT_W+3:0] rem_sh;
  logic [ROOT_W+3:0] trial;
  logic              ge;

  always_comb begin
    rem_sh = {rem_in, n_in[SUM_W-1 -: 2]};
    trial  = {2'b00, root_in, 2'b01};
    ge     = rem_sh >= trial;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vout <= 1'b0;
    end else if (en) begin
      vout <= vin;
    end
  end

  // Shift in one root bit; remainder never exceeds twice the root.
  always_ff @(posedge clk) begin
    if (en) begin
      n_out    <= n_in << 2;
      root_out <= {root_in[ROOT_W-2:0], ge};
      rem_out  <= ge ? (rem_sh[ROOT_W+1:0] - trial[ROOT_W+1:0]) : rem_sh[ROOT_W+1:0];
      side_out <= side_in;
    end
  end

endmodule
`default_nettype wire

/* hw/rtl/csru_div_cell.sv */
// One restoring-division cell: one quotient bit per cell.
// Depends on csru_pkg only through the common import.
`default_nettype none
module csru_div_cell import csru_pkg::*; #(
  parameter int NUM_W  = 16,
  parameter int DEN_W  = 32,
  parameter int SIDE_W = 1
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              en,
  input  wire logic              vin,
  input  wire logic [DEN_W-1:0]  rem_in,
  input  wire logic [NUM_W-1:0]  num_in,
  input  wire logic [NUM_W-1:0]  quo_in,
  input  wire logic [DEN_W-1:0]  den_in,
  input  wire logic [SIDE_W-1:0] side_in,
  output logic                   vout,
  output logic [DEN_W-1:0]       rem_out,
  output logic [NUM_W-1:0]       num_out,
  output logic [NUM_W-1:0]       quo_out,
  output logic [DEN_W-1:0]       den_out,
  output logic [SIDE_W-1:0]      side_out
);

  logic [DEN_W:0] rem_sh;
  logic [DEN_W:0] den_x;
  logic [DEN_W:0] diff;
  logic           ge;

  always_comb begin
    rem_sh = {rem_in, num_in[NUM_W-1]};
    den_x  = {1'b0, den_in};
    ge     = rem_sh >= den_x;
    diff   = rem_sh - den_x;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vout <= 1'b0;
    end else if (en) begin
      vout <= vin;
    end
  end

  // Remainder stays below the divisor, so the top bit drops.
  always_ff @(posedge clk) begin
    if (en) begin
      rem_out  <= ge ? diff[DEN_W-1:0] : rem_sh[DEN_W-1:0];
      num_out  <= num_in << 1;
      quo_out  <= {quo_in[NUM_W-2:0], ge};
      den_out  <= den_in;
      side_out <= side_in;
    end
  end

endmodule
`default_nettype wire

/* hw/rtl/csru_checker.sv */
// Port-level checks for the resistivity update unit, bound to its top level.
// Depends on csru_pkg.
`default_nettype none
module csru_checker import csru_pkg::*; (
  input wire logic             clk,
  input wire logic             rst,
  input wire logic             item_valid,
  input wire logic             item_ready,
  input wire item_t            item,
  input wire logic             result_valid,
  input wire logic             result_ready,
  input wire result_t          result,
  input wire logic             wr_en,
  input wire logic [1:0]       wr_index,
  input wire logic [REG_W-1:0] wr_data
);

  logic [REG_W-1:0] rmax_shadow;
  always_ff @(posedge clk) begin
    if (rst) rmax_shadow <= '0;
    else if (wr_en && wr_index == REG_RESIST_MAX) rmax_shadow <= wr_data;
  end

  a_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(result))
    else $error("stalled result changed");

  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !result_valid)
    else $error("result valid right after reset");

  a_ready: assert property (@(posedge clk) disable iff (rst)
    !item_ready |-> result_valid && !result_ready)
    else $error("input stalled without output backpressure");

  a_bypass: assert property (@(posedge clk) disable iff (rst)
    result_valid && rmax_shadow == '0 |-> !result.saturated)
    else $error("saturated set while update disabled");

endmodule

bind current_smoothstep_resistivity_update_unit csru_checker u_checker (.*);
`default_nettype wire
